@@ design/bstk_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package bstk_pkg;

  localparam int unsigned StackDepth = 8;
  localparam int unsigned AddrW      = $clog2(StackDepth);
  localparam int unsigned CountW     = $clog2(StackDepth + 1);
  localparam int unsigned DataW      = 32;

  typedef enum logic [1:0] {
    OP_PUSH    = 2'd0,
    OP_POP     = 2'd1,
    OP_PALCHK  = 2'd2,
    OP_DISPLAY = 2'd3
  } op_e;

  localparam logic [1:0] STATUS_OK        = 2'd0;
  localparam logic [1:0] STATUS_OVERFLOW  = 2'd1;
  localparam logic [1:0] STATUS_UNDERFLOW = 2'd2;

  typedef enum logic [3:0] {
    CMD_NONE,
    CMD_PUSH,
    CMD_OVERFLOW,
    CMD_UNDERFLOW,
    CMD_POP_START,
    CMD_POP_EMIT,
    CMD_PAL_TRIVIAL,
    CMD_PAL_START,
    CMD_PAL_STEP,
    CMD_DISP_START,
    CMD_DISP_STEP
  } cmd_e;

  typedef struct packed {
    logic count_zero;
    logic count_full;
    logic count_le1;
    logic pal_end;
    logic disp_last;
  } sts_t;

endpackage

`default_nettype wire

@@ design/bstk_ctrl.sv @@
`timescale 1ns / 1ps
`default_nettype none

module bstk_ctrl (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          start_i,
  input  wire logic [1:0]    op_i,
  input  wire bstk_pkg::sts_t sts_i,
  output bstk_pkg::cmd_e     cmd_o,
  output logic               busy_o
);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_POP  = 4'b0010,
    S_PAL  = 4'b0100,
    S_DISP = 4'b1000
  } state_e;

  state_e state_q, state_d;
  bstk_pkg::op_e op;

  assign op     = bstk_pkg::op_e'(op_i);
  assign busy_o = (state_q != S_IDLE);

  always_comb begin
    state_d = state_q;
    cmd_o   = bstk_pkg::CMD_NONE;
    unique case (state_q)
      S_IDLE: begin
        if (start_i) begin
          unique case (op)
            bstk_pkg::OP_PUSH: begin
              cmd_o = sts_i.count_full ? bstk_pkg::CMD_OVERFLOW : bstk_pkg::CMD_PUSH;
            end
            bstk_pkg::OP_POP: begin
              if (sts_i.count_zero) begin
                cmd_o = bstk_pkg::CMD_UNDERFLOW;
              end else begin
                cmd_o   = bstk_pkg::CMD_POP_START;
                state_d = S_POP;
              end
            end
            bstk_pkg::OP_PALCHK: begin
              if (sts_i.count_le1) begin
                cmd_o = bstk_pkg::CMD_PAL_TRIVIAL;
              end else begin
                cmd_o   = bstk_pkg::CMD_PAL_START;
                state_d = S_PAL;
              end
            end
            bstk_pkg::OP_DISPLAY: begin
              if (sts_i.count_zero) begin
                cmd_o = bstk_pkg::CMD_UNDERFLOW;
              end else begin
                cmd_o   = bstk_pkg::CMD_DISP_START;
                state_d = S_DISP;
              end
            end
            default: cmd_o = bstk_pkg::CMD_NONE;
          endcase
        end
      end
      S_POP: begin
        cmd_o   = bstk_pkg::CMD_POP_EMIT;
        state_d = S_IDLE;
      end
      S_PAL: begin
        cmd_o = bstk_pkg::CMD_PAL_STEP;
        if (sts_i.pal_end) begin
          state_d = S_IDLE;
        end
      end
      S_DISP: begin
        cmd_o = bstk_pkg::CMD_DISP_STEP;
        if (sts_i.disp_last) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

`ifndef SYNTH
  a_pop_one_cycle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_POP |=> state_q == S_IDLE)
    else $error("pop did not finish in one cycle");

  a_busy_blocks_cmd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != S_IDLE) |-> (cmd_o != bstk_pkg::CMD_PUSH && cmd_o != bstk_pkg::CMD_PAL_START
                             && cmd_o != bstk_pkg::CMD_DISP_START))
    else $error("start command issued while busy");

  a_state_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot(state_q))
    else $error("state register is not one-hot");
`endif

endmodule

`default_nettype wire

@@ design/bstk_dp.sv @@
`timescale 1ns / 1ps
`default_nettype none

module bstk_dp (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire bstk_pkg::cmd_e                     cmd_i,
  input  wire logic signed [bstk_pkg::DataW-1:0]  push_value_i,
  output bstk_pkg::sts_t                          sts_o,
  output logic                                    done_o,
  output logic signed [bstk_pkg::DataW-1:0]       data_value_o,
  output logic [1:0]                              status_o,
  output logic                                    is_palindrome_o,
  output logic                                    last_result_o
);

  localparam int unsigned AW = bstk_pkg::AddrW;
  localparam int unsigned CW = bstk_pkg::CountW;
  localparam int unsigned DW = bstk_pkg::DataW;

  logic [DW-1:0] stack_mem_q [bstk_pkg::StackDepth];
  logic [DW-1:0] rd_a_q, rd_b_q;

  logic [CW-1:0] count_q, count_d, count_m1;
  logic [AW-1:0] lo_q, lo_d, hi_q, hi_d;

  logic          res_vld_q, res_vld_d;
  logic [DW-1:0] res_data_q, res_data_d;
  logic [1:0]    res_status_q, res_status_d;
  logic          res_pal_q, res_pal_d;
  logic          res_last_q, res_last_d;

  logic          mismatch, pal_end, disp_last, mem_we;

  assign count_m1  = count_q - CW'(1);
  assign mismatch  = (rd_a_q != rd_b_q);
  assign pal_end   = mismatch || (({1'b0, lo_q} + (AW+1)'(2)) >= {1'b0, hi_q});
  assign disp_last = (lo_q == hi_q);
  assign mem_we    = (cmd_i == bstk_pkg::CMD_PUSH);

  assign sts_o.count_zero = (count_q == '0);
  assign sts_o.count_full = (count_q == CW'(bstk_pkg::StackDepth));
  assign sts_o.count_le1  = (count_q <= CW'(1));
  assign sts_o.pal_end    = pal_end;
  assign sts_o.disp_last  = disp_last;

  always_comb begin
    count_d      = count_q;
    lo_d         = lo_q;
    hi_d         = hi_q;
    res_vld_d    = 1'b0;
    res_data_d   = '0;
    res_status_d = bstk_pkg::STATUS_OK;
    res_pal_d    = 1'b0;
    res_last_d   = 1'b1;
    unique case (cmd_i)
      bstk_pkg::CMD_NONE: begin
        res_vld_d = 1'b0;
      end
      bstk_pkg::CMD_PUSH: begin
        count_d   = count_q + CW'(1);
        res_vld_d = 1'b1;
      end
      bstk_pkg::CMD_OVERFLOW: begin
        res_vld_d    = 1'b1;
        res_status_d = bstk_pkg::STATUS_OVERFLOW;
      end
      bstk_pkg::CMD_UNDERFLOW: begin
        res_vld_d    = 1'b1;
        res_status_d = bstk_pkg::STATUS_UNDERFLOW;
      end
      bstk_pkg::CMD_POP_START: begin
        count_d = count_m1;
        lo_d    = count_m1[AW-1:0];
      end
      bstk_pkg::CMD_POP_EMIT: begin
        res_vld_d  = 1'b1;
        res_data_d = rd_a_q;
      end
      bstk_pkg::CMD_PAL_TRIVIAL: begin
        count_d   = '0;
        res_vld_d = 1'b1;
        res_pal_d = 1'b1;
      end
      bstk_pkg::CMD_PAL_START: begin
        count_d = '0;
        lo_d    = '0;
        hi_d    = count_m1[AW-1:0];
      end
      bstk_pkg::CMD_PAL_STEP: begin
        if (pal_end) begin
          res_vld_d = 1'b1;
          res_pal_d = !mismatch;
        end else begin
          lo_d = lo_q + AW'(1);
          hi_d = hi_q - AW'(1);
        end
      end
      bstk_pkg::CMD_DISP_START: begin
        lo_d = '0;
        hi_d = count_m1[AW-1:0];
      end
      bstk_pkg::CMD_DISP_STEP: begin
        res_vld_d  = 1'b1;
        res_data_d = rd_a_q;
        res_last_d = disp_last;
        if (!disp_last) begin
          lo_d = lo_q + AW'(1);
        end
      end
      default: res_vld_d = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      stack_mem_q[count_q[AW-1:0]] <= push_value_i;
    end
    rd_a_q <= stack_mem_q[lo_d];
    rd_b_q <= stack_mem_q[hi_d];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q   <= '0;
      lo_q      <= '0;
      hi_q      <= '0;
      res_vld_q <= 1'b0;
    end else begin
      count_q   <= count_d;
      lo_q      <= lo_d;
      hi_q      <= hi_d;
      res_vld_q <= res_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_data_q   <= res_data_d;
    res_status_q <= res_status_d;
    res_pal_q    <= res_pal_d;
    res_last_q   <= res_last_d;
  end

  assign done_o          = res_vld_q;
  assign data_value_o    = res_data_q;
  assign status_o        = res_status_q;
  assign is_palindrome_o = res_pal_q;
  assign last_result_o   = res_last_q;

`ifndef SYNTH
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(bstk_pkg::StackDepth))
    else $error("element count above stack depth");

  a_pal_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i == bstk_pkg::CMD_PAL_STEP |-> lo_q < hi_q)
    else $error("palindrome indices crossed");

  a_push_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i == bstk_pkg::CMD_PUSH |=> count_q == $past(count_q) + CW'(1))
    else $error("push did not advance the count");
`endif

endmodule

`default_nettype wire

@@ design/bounded_stack_with_palindrome_top.sv @@
// Channel  | Ports                                               | Transfer when
// ---------+-----------------------------------------------------+------------------------
// command  | start_i, busy_o, op_i, push_value_i                 | start_i high, busy_o low
// result   | done_o, data_value_o, status_o, is_palindrome_o,    | done_o high (one cycle)
//          | last_result_o                                       |
//
// Push, overflow and underflow are handled in the start cycle; their result shows the cycle after.
// Pop passes through the S_POP state for the registered read of the stack memory.
// Display reads out every stored element, one stored word read per cycle.
// The palindrome check compares one pair per cycle, from both ends toward the middle.
// Reset empties the stack; the memory itself is not cleared.
// The receiver cannot stall; a result is shown for exactly one cycle.
`timescale 1ns / 1ps
`default_nettype none

module bounded_stack_with_palindrome_top (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               start_i,
  output logic                                    busy_o,
  input  wire logic [1:0]                         op_i,
  input  wire logic signed [bstk_pkg::DataW-1:0]  push_value_i,
  output logic                                    done_o,
  output logic signed [bstk_pkg::DataW-1:0]       data_value_o,
  output logic [1:0]                              status_o,
  output logic                                    is_palindrome_o,
  output logic                                    last_result_o
);

  bstk_pkg::cmd_e cmd;
  bstk_pkg::sts_t sts;

  bstk_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_i),
    .op_i    (op_i),
    .sts_i   (sts),
    .cmd_o   (cmd),
    .busy_o  (busy_o)
  );

  bstk_dp u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .push_value_i    (push_value_i),
    .sts_o           (sts),
    .done_o          (done_o),
    .data_value_o    (data_value_o),
    .status_o        (status_o),
    .is_palindrome_o (is_palindrome_o),
    .last_result_o   (last_result_o)
  );

endmodule

`default_nettype wire
